[rtl/mag_pkg.sv]
package mag_pkg;

    // running sample count width
    localparam int COUNT_BITS = 32;

    localparam int FRAME_W  = 12;
    localparam int TIME_W   = 29;
    localparam int RATE_W   = 16;
    localparam int KBPS_W   = 9;
    localparam int NUM_W    = 26;
    localparam int FACTOR_W = 18;
    localparam int SAMP_W   = 11;

    localparam int MS_PER_S = 1000;

    // timestamp dividend is count * 1000, radix-4 steps
    localparam int DIV_BITS  = COUNT_BITS + 10;
    localparam int DIV_STEPS = (DIV_BITS + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [2:0] SYNC_BITS = 3'b111;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_NOSYNC  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] VER_MPEG25    = 2'b00;
    localparam logic [1:0] VER_RESERVED  = 2'b01;
    localparam logic [1:0] VER_MPEG2     = 2'b10;
    localparam logic [1:0] VER_MPEG1     = 2'b11;

    localparam logic [1:0] LAYER_RESERVED = 2'b00;
    localparam logic [1:0] LAYER_III      = 2'b01;
    localparam logic [1:0] LAYER_II       = 2'b10;
    localparam logic [1:0] LAYER_I        = 2'b11;

    localparam logic [FACTOR_W-1:0] FACTOR_L1     = 18'd12000;
    localparam logic [FACTOR_W-1:0] FACTOR_LSF_L3 = 18'd72000;
    localparam logic [FACTOR_W-1:0] FACTOR_FULL   = 18'd144000;

    localparam logic [SAMP_W-1:0] SAMPLES_L1     = 11'd384;
    localparam logic [SAMP_W-1:0] SAMPLES_LSF_L3 = 11'd576;
    localparam logic [SAMP_W-1:0] SAMPLES_FULL   = 11'd1152;

    typedef enum logic [1:0] {
        KIND_L1     = 2'd0,
        KIND_LSF_L3 = 2'd1,
        KIND_FULL   = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] version_layer_byte;
        logic [7:0] rate_byte;
    } mag_hdr_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame_bytes;
        logic [TIME_W-1:0]  time_ms;
    } mag_res_t;

    // decoded header held in the front stage
    typedef struct packed {
        logic [1:0]        status;
        logic [KBPS_W-1:0] kbps;
        logic [RATE_W-1:0] rate;
        logic              pad;
        frame_kind_t       kind;
    } mag_dec_t;

    // one queued job for the back end
    typedef struct packed {
        logic [1:0]        status;
        logic [NUM_W-1:0]  num;
        logic [RATE_W-1:0] rate;
        logic              pad;
        logic              layer1;
        logic [SAMP_W-1:0] samples;
    } mag_job_t;

    typedef struct packed {
        logic [1:0]        q;
        logic [RATE_W-1:0] rem;
    } div_res_t;

    localparam logic [KBPS_W-1:0] KBPS_LSF_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_LSF_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};

    // bitrate in kbit/s, zero for free format, bad index or reserved layer
    function automatic logic [KBPS_W-1:0] kbps_lookup(
        input logic       mpeg1,
        input logic [1:0] lay,
        input logic [3:0] bri
    );
        logic [KBPS_W-1:0] k;
        k = '0;
        case (lay)
            LAYER_I:   k = mpeg1 ? KBPS_V1_L1[bri] : KBPS_LSF_L1[bri];
            LAYER_II:  k = mpeg1 ? KBPS_V1_L2[bri] : KBPS_LSF_L23[bri];
            LAYER_III: k = mpeg1 ? KBPS_V1_L3[bri] : KBPS_LSF_L23[bri];
            default:   k = '0;
        endcase
        return k;
    endfunction

    // sample rate in Hz, zero when reserved
    function automatic logic [RATE_W-1:0] rate_lookup(
        input logic [1:0] ver,
        input logic [1:0] sri
    );
        logic [RATE_W-1:0] r;
        r = '0;
        case (ver)
            VER_MPEG1:
                case (sri)
                    2'd0:    r = 16'd44100;
                    2'd1:    r = 16'd48000;
                    2'd2:    r = 16'd32000;
                    default: r = '0;
                endcase
            VER_MPEG2:
                case (sri)
                    2'd0:    r = 16'd22050;
                    2'd1:    r = 16'd24000;
                    2'd2:    r = 16'd16000;
                    default: r = '0;
                endcase
            VER_MPEG25:
                case (sri)
                    2'd0:    r = 16'd11025;
                    2'd1:    r = 16'd12000;
                    2'd2:    r = 16'd8000;
                    default: r = '0;
                endcase
            default: r = '0;
        endcase
        return r;
    endfunction

    // two restoring division steps, remainder stays below divisor
    function automatic div_res_t div_pair(
        input logic [RATE_W-1:0] rem,
        input logic [1:0]        bits,
        input logic [RATE_W-1:0] d
    );
        logic [RATE_W:0]   t;
        logic [RATE_W-1:0] r;
        div_res_t          o;
        t = {rem, bits[1]};
        if (t >= {1'b0, d})
        begin
            r      = RATE_W'(t - {1'b0, d});
            o.q[1] = 1'b1;
        end
        else
        begin
            r      = t[RATE_W-1:0];
            o.q[1] = 1'b0;
        end
        t = {r, bits[0]};
        if (t >= {1'b0, d})
        begin
            o.rem  = RATE_W'(t - {1'b0, d});
            o.q[0] = 1'b1;
        end
        else
        begin
            o.rem  = t[RATE_W-1:0];
            o.q[0] = 1'b0;
        end
        return o;
    endfunction

endpackage

[rtl/mag_front.sv]
module mag_front
    import mag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hdr_valid,
    input  mag_hdr_t hdr,
    output logic     hdr_stall,
    output logic     push_valid,
    output mag_job_t push_job,
    input  logic     push_full
);

    logic     dec_valid_reg, dec_valid_next;
    mag_dec_t dec_reg;
    mag_dec_t dec_now;
    logic     accept;

    logic [1:0] ver, lay;
    logic       sync_ok;

    logic [FACTOR_W-1:0]       factor;
    logic [KBPS_W+FACTOR_W-1:0] product;

    assign hdr_stall = dec_valid_reg && push_full;
    assign accept    = hdr_valid && !hdr_stall;

    // classify the header bytes
    always_comb
    begin
        ver     = hdr.version_layer_byte[4:3];
        lay     = hdr.version_layer_byte[2:1];
        sync_ok = (hdr.sync_byte == SYNC_BYTE) && (hdr.version_layer_byte[7:5] == SYNC_BITS);

        dec_now.kbps = kbps_lookup(ver == VER_MPEG1, lay, hdr.rate_byte[7:4]);
        dec_now.rate = rate_lookup(ver, hdr.rate_byte[3:2]);
        dec_now.pad  = hdr.rate_byte[1];

        if (lay == LAYER_I)
            dec_now.kind = KIND_L1;
        else if (lay == LAYER_III && ver != VER_MPEG1)
            dec_now.kind = KIND_LSF_L3;
        else
            dec_now.kind = KIND_FULL;

        if (!sync_ok)
            dec_now.status = ST_NOSYNC;
        else if (ver == VER_RESERVED || lay == LAYER_RESERVED
                 || dec_now.kbps == '0 || dec_now.rate == '0)
            dec_now.status = ST_INVALID;
        else
            dec_now.status = ST_VALID;
    end

    always_comb
    begin
        dec_valid_next = dec_valid_reg;
        if (accept)
            dec_valid_next = 1'b1;
        else if (dec_valid_reg && !push_full)
            dec_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_valid_reg <= 1'b0;
        else
            dec_valid_reg <= dec_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            dec_reg <= dec_now;
    end

    // bitrate times length factor, then into the queue
    always_comb
    begin
        case (dec_reg.kind)
            KIND_L1:     factor = FACTOR_L1;
            KIND_LSF_L3: factor = FACTOR_LSF_L3;
            default:     factor = FACTOR_FULL;
        endcase
        product = (KBPS_W + FACTOR_W)'(dec_reg.kbps) * (KBPS_W + FACTOR_W)'(factor);

        push_job.status = dec_reg.status;
        push_job.num    = product[NUM_W-1:0];
        push_job.rate   = dec_reg.rate;
        push_job.pad    = dec_reg.pad;
        push_job.layer1 = (dec_reg.kind == KIND_L1);
        case (dec_reg.kind)
            KIND_L1:     push_job.samples = SAMPLES_L1;
            KIND_LSF_L3: push_job.samples = SAMPLES_LSF_L3;
            default:     push_job.samples = SAMPLES_FULL;
        endcase
    end

    assign push_valid = dec_valid_reg;

endmodule

[rtl/mag_queue.sv]
module mag_queue
    import mag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  mag_job_t push_job,
    output logic     full,
    output logic     pop_valid,
    output mag_job_t pop_job,
    input  logic     pop
);

    mag_job_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/mag_back.sv]
module mag_back
    import mag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  mag_job_t q_job,
    output logic     q_pop,
    output logic     res_valid,
    output mag_res_t res,
    input  logic     res_stall
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    mag_job_t            job_reg, job_next;
    logic [RATE_W-1:0]   rem_t_reg, rem_t_next;
    logic [RATE_W-1:0]   rem_l_reg, rem_l_next;
    logic [DIV_W-1:0]    quo_t_reg, quo_t_next;
    logic [DIV_W-1:0]    quo_l_reg, quo_l_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                res_valid_reg, res_valid_next;
    mag_res_t            res_reg, res_next;

    logic                out_free;
    div_res_t            step_t, step_l;
    logic [FRAME_W-1:0]  len_sum;

    assign out_free = !res_valid_reg || !res_stall;
    assign step_t   = div_pair(rem_t_reg, quo_t_reg[DIV_W-1 -: 2], job_reg.rate);
    assign step_l   = div_pair(rem_l_reg, quo_l_reg[DIV_W-1 -: 2], job_reg.rate);
    assign len_sum  = quo_l_reg[FRAME_W-1:0] + FRAME_W'(job_reg.pad);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        rem_t_next     = rem_t_reg;
        rem_l_next     = rem_l_reg;
        quo_t_next     = quo_t_reg;
        quo_l_next     = quo_l_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    if (q_job.status != ST_VALID)
                    begin
                        res_next.status      = q_job.status;
                        res_next.frame_bytes = '0;
                        res_next.time_ms     = '0;
                        res_valid_next       = 1'b1;
                    end
                    else
                    begin
                        rem_t_next = '0;
                        rem_l_next = '0;
                        quo_t_next = DIV_W'(total_reg) * DIV_W'(MS_PER_S);
                        quo_l_next = DIV_W'(q_job.num);
                        step_next  = STEP_W'(DIV_STEPS);
                        state_next = B_RUN;
                    end
                end
            end
            B_RUN:
            begin
                rem_t_next = step_t.rem;
                rem_l_next = step_l.rem;
                quo_t_next = {quo_t_reg[DIV_W-3:0], step_t.q};
                quo_l_next = {quo_l_reg[DIV_W-3:0], step_l.q};
                step_next  = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    res_next.status      = ST_VALID;
                    res_next.frame_bytes = job_reg.layer1
                                         ? {len_sum[FRAME_W-3:0], 2'b00} : len_sum;
                    res_next.time_ms     = quo_t_reg[TIME_W-1:0];
                    res_valid_next       = 1'b1;
                    total_next           = total_reg + COUNT_BITS'(job_reg.samples);
                    state_next           = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        rem_t_reg <= rem_t_next;
        rem_l_reg <= rem_l_next;
        quo_t_reg <= quo_t_next;
        quo_l_reg <= quo_l_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != ST_VALID
        |-> res_reg.frame_bytes == '0 && res_reg.time_ms == '0)
        else $error("rejected header carries nonzero fields");

    a_total_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != $past(total_reg) |-> $past(state_reg == B_DONE))
        else $error("sample total moved outside frame completion");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == B_IDLE && q_valid && out_free)
        else $error("queue popped while busy");

endmodule

[rtl/mpeg_audio_frame_header_timing_core.sv]
// mpeg audio frame header timing core
//
// hdr channel: one request carries the first three bytes of a candidate
// frame (sync, version/layer, bitrate/rate/padding). res channel: one
// request per header with status (valid, no sync, invalid), frame length in
// bytes and the frame start time in milliseconds.
// front stage decodes and looks up bitrate and sample rate, a two-entry
// job queue sits between it and the back end, which runs a radix-4
// restoring divider (two lanes: frame length and timestamp) whose step
// count DIV_STEPS follows from COUNT_BITS = 32.
// a rejected header passes the decode register, a queue entry and the
// result register; a valid frame also runs the B_RUN divider loop and
// B_DONE before the result register is loaded.
// the back end pops a new job only in B_IDLE, so the next job waits until
// a valid frame leaves B_DONE; rejected headers are answered from B_IDLE.
// reset clears the running sample count and all valid flags; no clearing
// pass is needed. while res_stall is high the result register holds, the
// queue fills and then hdr_stall rises; nothing is dropped.
module mpeg_audio_frame_header_timing_core
    import mag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hdr_valid,
    input  mag_hdr_t hdr,
    output logic     hdr_stall,
    output logic     res_valid,
    output mag_res_t res,
    input  logic     res_stall
);

    // front to queue
    logic     push_valid;
    mag_job_t push_job;
    logic     push_full;

    // queue to back end
    logic     q_valid;
    mag_job_t q_job;
    logic     q_pop;

    // header decode and table lookups
    mag_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdr_valid  (hdr_valid),
        .hdr        (hdr),
        .hdr_stall  (hdr_stall),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_full  (push_full)
    );

    // short job queue decoupling decode from division
    mag_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (push_full),
        .pop_valid  (q_valid),
        .pop_job    (q_job),
        .pop        (q_pop)
    );

    // divider, sample count and result register
    mag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

endmodule

[verif/tb_mpeg_audio_frame_header_timing_core.sv]
`timescale 1ns / 1ps

// testbench for the mpeg audio frame header timing core
// hdr requests carry three header bytes, res requests carry status, frame
// length and start time; every accepted result is compared field by field
// against a typed-in result or a running model of the decode and sample count
module tb_mpeg_audio_frame_header_timing_core;
    import mag_pkg::*;

    // quiet cycles (no accepted request on either side) before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time after the last result, well above the valid-frame latency
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int IDLE_PCT       = 31;
    // random items in this window run with neither side idling
    localparam int BURST_FIRST    = 400;
    localparam int BURST_LAST     = 650;
    // sender holds off here until every pending result is out
    localparam int HOLD_AT        = 900;

    // bitrate in kbit/s indexed by [mpeg1][layer code - 1][bitrate index]
    localparam int unsigned KBPS_BY_LAYER [2][3][16] = '{
        '{
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
        },
        '{
            '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
            '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
        }
    };

    // sample rate in Hz indexed by [version code][rate index], zero if reserved
    localparam int unsigned RATE_HZ [4][4] = '{
        '{11025, 12000, 8000, 0},
        '{0, 0, 0, 0},
        '{22050, 24000, 16000, 0},
        '{44100, 48000, 32000, 0}
    };

    // one row of the directed table: header, and a typed-in result where the
    // answer is obvious, otherwise the running model supplies it
    typedef struct packed {
        mag_hdr_t hdr;
        logic     known;
        mag_res_t res;
    } header_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam header_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first frame after reset: mpeg1 layer iii, 128 kbit/s, 44.1 kHz
        '{'{8'hFF, 8'hFB, 8'h90}, 1'b1, '{ST_VALID, 12'd417, 29'd0}},
        // same with padding, start time now 1152 samples in
        '{'{8'hFF, 8'hFB, 8'h92}, 1'b1, '{ST_VALID, 12'd418, 29'd26}},
        // no sync: all zero, sync byte one short, sync bits clear or partial
        '{'{8'h00, 8'h00, 8'h00}, 1'b1, '{ST_NOSYNC, 12'd0, 29'd0}},
        '{'{8'hFE, 8'hFF, 8'hFF}, 1'b1, '{ST_NOSYNC, 12'd0, 29'd0}},
        '{'{8'hFF, 8'h1F, 8'hFF}, 1'b1, '{ST_NOSYNC, 12'd0, 29'd0}},
        '{'{8'hFF, 8'hDF, 8'h90}, 1'b1, '{ST_NOSYNC, 12'd0, 29'd0}},
        // reserved version
        '{'{8'hFF, 8'hEB, 8'h90}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // reserved layer
        '{'{8'hFF, 8'hF9, 8'h90}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // free format bitrate
        '{'{8'hFF, 8'hFB, 8'h0F}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // bad bitrate index
        '{'{8'hFF, 8'hFB, 8'hF0}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // reserved sample rate
        '{'{8'hFF, 8'hFB, 8'h9C}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // every version and layer, protection and private bits mixed in
        '{'{8'hFF, 8'hFF, 8'hE8}, 1'b0, '0},
        '{'{8'hFF, 8'hFD, 8'hE6}, 1'b0, '0},
        '{'{8'hFF, 8'hF7, 8'h13}, 1'b0, '0},
        '{'{8'hFF, 8'hF5, 8'hE5}, 1'b0, '0},
        '{'{8'hFF, 8'hF3, 8'hA9}, 1'b0, '0},
        '{'{8'hFF, 8'hE7, 8'h1A}, 1'b0, '0},
        // longest frame: mpeg2.5 layer ii, 160 kbit/s, 8 kHz, padded
        '{'{8'hFF, 8'hE5, 8'hEA}, 1'b0, '0},
        '{'{8'hFF, 8'hE3, 8'h81}, 1'b0, '0},
        // all ones: bad bitrate index
        '{'{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}},
        // reserved version and reserved layer together
        '{'{8'hFF, 8'hE9, 8'h90}, 1'b1, '{ST_INVALID, 12'd0, 29'd0}}
    };

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     hdr_valid = 1'b0;
    mag_hdr_t hdr       = '0;
    logic     hdr_stall;
    logic     res_valid;
    mag_res_t res;
    logic     res_stall = 1'b0;

    // model state: running sample count, wraps like the block's counter
    logic [COUNT_BITS-1:0] samples_seen = '0;
    // results owed by the block, oldest first
    mag_res_t              frame_results_due [$];
    int                    mismatches = 0;
    // chance in percent that a side idles in a given cycle
    int                    send_idle_pct  = IDLE_PCT;
    int                    stall_pct      = IDLE_PCT;

    mpeg_audio_frame_header_timing_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr       (hdr),
        .hdr_stall (hdr_stall),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // decode one header and advance the sample count for valid frames
    function automatic mag_res_t decode_frame_header(input mag_hdr_t h);
        mag_res_t        r;
        logic [1:0]      ver;
        logic [1:0]      lay;
        logic [3:0]      bri;
        logic [1:0]      sri;
        int unsigned     kbps;
        int unsigned     hz;
        int unsigned     len;
        int unsigned     nsamp;
        longint unsigned cnt;
        longint unsigned ms;
        r        = '0;
        r.status = ST_NOSYNC;
        if (h.sync_byte != SYNC_BYTE || h.version_layer_byte[7:5] != SYNC_BITS)
            return r;
        ver      = h.version_layer_byte[4:3];
        lay      = h.version_layer_byte[2:1];
        bri      = h.rate_byte[7:4];
        sri      = h.rate_byte[3:2];
        r.status = ST_INVALID;
        if (ver == VER_RESERVED || lay == LAYER_RESERVED)
            return r;
        kbps = KBPS_BY_LAYER[(ver == VER_MPEG1) ? 1 : 0][int'(lay) - 1][bri];
        hz   = RATE_HZ[ver][sri];
        if (kbps == 0 || hz == 0)
            return r;
        // frame length by layer; lower sampling frequencies halve layer iii
        if (lay == LAYER_I)
        begin
            len   = (12 * kbps * 1000 / hz + h.rate_byte[1]) * 4;
            nsamp = 384;
        end
        else if (lay == LAYER_III && ver != VER_MPEG1)
        begin
            len   = 72 * kbps * 1000 / hz + h.rate_byte[1];
            nsamp = 576;
        end
        else
        begin
            len   = 144 * kbps * 1000 / hz + h.rate_byte[1];
            nsamp = 1152;
        end
        // start time in ms from the count before this frame
        cnt           = samples_seen;
        ms            = (cnt / hz) * 1000 + ((cnt % hz) * 1000) / hz;
        r.status      = ST_VALID;
        r.frame_bytes = len[FRAME_W-1:0];
        r.time_ms     = ms[TIME_W-1:0];
        samples_seen  = samples_seen + nsamp;
        return r;
    endfunction

    // mostly well-formed headers with random content, some near misses,
    // some plain noise
    function automatic mag_hdr_t random_header();
        mag_hdr_t    h;
        int unsigned pick;
        h.sync_byte          = 8'($urandom_range(255));
        h.version_layer_byte = 8'($urandom_range(255));
        h.rate_byte          = 8'($urandom_range(255));
        pick                 = $urandom_range(99);
        if (pick < 85)
        begin
            h.sync_byte               = SYNC_BYTE;
            h.version_layer_byte[7:5] = SYNC_BITS;
            // legal codes only, so the frame reaches the divider
            if (pick < 70)
            begin
                case ($urandom_range(2))
                    0:       h.version_layer_byte[4:3] = VER_MPEG25;
                    1:       h.version_layer_byte[4:3] = VER_MPEG2;
                    default: h.version_layer_byte[4:3] = VER_MPEG1;
                endcase
                case ($urandom_range(2))
                    0:       h.version_layer_byte[2:1] = LAYER_I;
                    1:       h.version_layer_byte[2:1] = LAYER_II;
                    default: h.version_layer_byte[2:1] = LAYER_III;
                endcase
                h.rate_byte[7:4] = 4'($urandom_range(14, 1));
                h.rate_byte[3:2] = 2'($urandom_range(2));
            end
        end
        else if (pick < 92)
        begin
            // sync byte right, second byte left to chance
            h.sync_byte = SYNC_BYTE;
        end
        return h;
    endfunction

    // one hdr request: random idle first, then hold until accepted and
    // record what the block owes for it
    task automatic send_header(input mag_hdr_t h, input mag_res_t owed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hdr_valid <= 1'b0;
            @(posedge clk);
        end
        hdr_valid <= 1'b1;
        hdr       <= h;
        @(posedge clk);
        while (hdr_stall)
            @(posedge clk);
        frame_results_due.push_back(owed);
    endtask

    // wait with the hdr side quiet until every owed result is out
    task automatic wait_results_out();
        hdr_valid <= 1'b0;
        @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
    endtask

    // stimulus: reset, directed table, random headers, then drain
    initial
    begin : stimulus
        mag_res_t owed;
        mag_hdr_t h;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            // run the model on every row so the sample count stays in step
            owed = decode_frame_header(DIRECTED[i].hdr);
            if (DIRECTED[i].known)
                owed = DIRECTED[i].res;
            send_header(DIRECTED[i].hdr, owed);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= BURST_FIRST && n < BURST_LAST)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                stall_pct     = IDLE_PCT;
            end
            if (n == HOLD_AT)
                wait_results_out();
            h    = random_header();
            owed = decode_frame_header(h);
            send_header(h, owed);
        end

        wait_results_out();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_mpeg_audio_frame_header_timing_core passed");
        else
            $display("tb_mpeg_audio_frame_header_timing_core failed");
        $finish;
    end

    // res side: random stall, and compare each accepted result with the
    // oldest one owed
    always @(posedge clk)
    begin : res_check
        mag_res_t want;
        res_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && res_valid && !res_stall)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("result with none owed: status %0d frame_bytes %0d time_ms %0d",
                       res.status, res.frame_bytes, res.time_ms);
                mismatches++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    mismatches++;
                end
                if (res.frame_bytes !== want.frame_bytes)
                begin
                    $error("frame_bytes: expected %0d, got %0d",
                           want.frame_bytes, res.frame_bytes);
                    mismatches++;
                end
                if (res.time_ms !== want.time_ms)
                begin
                    $error("time_ms: expected %0d, got %0d", want.time_ms, res.time_ms);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no accepted request on either side ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_mpeg_audio_frame_header_timing_core failed");
        $finish;
    end

endmodule

[mpeg_audio_frame_header_timing_core.f]
rtl/mag_pkg.sv
rtl/mag_front.sv
rtl/mag_queue.sv
rtl/mag_back.sv
rtl/mpeg_audio_frame_header_timing_core.sv
verif/tb_mpeg_audio_frame_header_timing_core.sv
